FILE: rtl/fbrf_pkg.sv
package fbrf_pkg;

    // Canvas geometry
    localparam int CANVAS_WIDTH  = 256;
    localparam int CANVAS_HEIGHT = 256;
    localparam int PIXEL_COUNT   = CANVAS_WIDTH * CANVAS_HEIGHT;

    // Counter and address widths (at least one bit each)
    localparam int COL_W  = (CANVAS_WIDTH  > 1) ? $clog2(CANVAS_WIDTH)  : 1;
    localparam int ROW_W  = (CANVAS_HEIGHT > 1) ? $clog2(CANVAS_HEIGHT) : 1;
    localparam int ADDR_W = (PIXEL_COUNT   > 1) ? $clog2(PIXEL_COUNT)   : 1;

    // Alpha byte of every drawn pixel
    localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;

    // Signed coordinate wide enough for x + w - t on 16-bit inputs
    typedef logic signed [18:0] t_coord;

    typedef enum logic [2:0] {
        MODE_CLEAR  = 3'd0,
        MODE_SET    = 3'd1,
        MODE_FILL   = 3'd2,
        MODE_BORDER = 3'd3,
        MODE_READ   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CLIP,
        ST_FILL,
        ST_READ,
        ST_RDCAP,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/framebuffer_rect_fill_engine.sv
// Rectangle fill engine over a CANVAS_WIDTH x CANVAS_HEIGHT frame store of 32-bit words
// held in one single-port synchronous RAM, one pixel write per clock while filling. Every
// command returns one result transaction. Each rectangle to draw is set up first with edge
// sums, then with clipping, and then filled pixel by pixel, row by row. A draw border runs
// four such fills, with overlaps written twice; a clear fills the whole canvas. The result
// cycle stretches while the output register still holds an unaccepted result. After reset
// the engine clears the store to zero with the same sweep as a clear, with o_ready low. A
// new command is taken while the previous result still waits in the output register.
module framebuffer_rect_fill_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_rect_width,
    input  logic signed [15:0] i_rect_height,
    input  logic signed [15:0] i_border_thickness,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_pixel_word,
    output logic        o_on_canvas
);
    import fbrf_pkg::*;

    localparam t_coord           CW_C = t_coord'(CANVAS_WIDTH);
    localparam t_coord           CH_C = t_coord'(CANVAS_HEIGHT);
    localparam logic [ADDR_W-1:0] CW_A = ADDR_W'(CANVAS_WIDTH);

    // Frame store
    logic [31:0] mem_frame [PIXEL_COUNT];
    logic [31:0] r_mem_q;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;

    // Control and command registers
    t_state r_state, n_state;
    t_mode  r_mode,  n_mode;
    logic   r_init,  n_init;
    logic [1:0] r_fidx, n_fidx;
    logic   r_hit,   n_hit;
    logic   r_inside, n_inside;
    logic [31:0] r_color, n_color;
    logic [31:0] r_word,  n_word;
    t_coord r_x, n_x, r_y, n_y, r_w, n_w, r_h, n_h, r_t, n_t;

    // Current fill edges and clipped bounds
    t_coord r_sx, n_sx, r_ex, n_ex, r_sy, n_sy, r_ey, n_ey;
    logic [COL_W-1:0] r_x0, n_x0, r_xl, n_xl, r_ix, n_ix;
    logic [ROW_W-1:0] r_yl, n_yl, r_iy, n_iy;

    // Output register
    logic        r_o_valid, n_o_valid;
    logic [31:0] r_o_word,  n_o_word;
    logic        r_o_hit,   n_o_hit;

    // Clip terms
    t_coord cx0, cx1, cy0, cy1, cx1m, cy1m;
    logic   empty;
    logic   rd_inside;
    logic [ADDR_W-1:0] fill_addr, rd_addr;

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_o_valid;
    assign o_pixel_word = r_o_word;
    assign o_on_canvas  = r_o_hit;

    // Clamp the current rectangle to the canvas
    always_comb begin
        cx0   = (r_sx < 0) ? '0 : r_sx;
        cy0   = (r_sy < 0) ? '0 : r_sy;
        cx1   = (r_ex > CW_C) ? CW_C : r_ex;
        cy1   = (r_ey > CH_C) ? CH_C : r_ey;
        cx1m  = cx1 - 19'sd1;
        cy1m  = cy1 - 19'sd1;
        empty = (cx0 >= cx1) || (cy0 >= cy1);
    end

    // Addresses
    assign fill_addr = ADDR_W'(r_iy) * CW_A + ADDR_W'(r_ix);
    assign rd_addr   = ADDR_W'(r_y[ROW_W-1:0]) * CW_A + ADDR_W'(r_x[COL_W-1:0]);
    assign rd_inside = (r_x >= 0) && (r_x < CW_C) && (r_y >= 0) && (r_y < CH_C);
    assign mem_addr  = (r_state == ST_FILL) ? fill_addr : rd_addr;
    assign mem_we    = (r_state == ST_FILL);

    // Frame store port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_frame[mem_addr] <= r_color;
        end
        r_mem_q <= mem_frame[mem_addr];
    end

    // Sequencer: next state and datapath
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_init    = r_init;
        n_fidx    = r_fidx;
        n_hit     = r_hit;
        n_inside  = r_inside;
        n_color   = r_color;
        n_word    = r_word;
        n_x = r_x; n_y = r_y; n_w = r_w; n_h = r_h; n_t = r_t;
        n_sx = r_sx; n_ex = r_ex; n_sy = r_sy; n_ey = r_ey;
        n_x0 = r_x0; n_xl = r_xl; n_ix = r_ix;
        n_yl = r_yl; n_iy = r_iy;
        n_o_valid = r_o_valid && !i_ready;
        n_o_word  = r_o_word;
        n_o_hit   = r_o_hit;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_mode  = t_mode'(i_mode);
                    n_x     = t_coord'(i_pos_x);
                    n_y     = t_coord'(i_pos_y);
                    n_w     = t_coord'(i_rect_width);
                    n_h     = t_coord'(i_rect_height);
                    n_t     = t_coord'(i_border_thickness);
                    n_color = ALPHA_OPAQUE | {8'h00, i_blue, i_green, i_red};
                    n_fidx  = '0;
                    n_hit   = 1'b0;
                    n_word  = '0;
                    case (t_mode'(i_mode))
                        MODE_CLEAR, MODE_SET, MODE_FILL, MODE_BORDER: n_state = ST_SETUP;
                        MODE_READ: n_state = ST_READ;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_SETUP: begin
                // Edges of the rectangle for this fill
                n_sx = r_x;
                n_ex = r_x + r_w;
                n_sy = r_y;
                n_ey = r_y + r_h;
                case (r_mode)
                    MODE_CLEAR: begin
                        n_sx = '0; n_ex = CW_C; n_sy = '0; n_ey = CH_C;
                    end
                    MODE_SET: begin
                        n_ex = r_x + 19'sd1;
                        n_ey = r_y + 19'sd1;
                    end
                    MODE_BORDER: begin
                        case (r_fidx)
                            2'd0: n_ey = r_y + r_t;
                            2'd1: n_sy = r_y + r_h - r_t;
                            2'd2: n_ex = r_x + r_t;
                            default: n_sx = r_x + r_w - r_t;
                        endcase
                    end
                    default: ;
                endcase
                n_state = ST_CLIP;
            end
            ST_CLIP: begin
                if (!empty) begin
                    n_hit   = 1'b1;
                    n_x0    = cx0[COL_W-1:0];
                    n_ix    = cx0[COL_W-1:0];
                    n_xl    = cx1m[COL_W-1:0];
                    n_iy    = cy0[ROW_W-1:0];
                    n_yl    = cy1m[ROW_W-1:0];
                    n_state = ST_FILL;
                end else if (r_mode == MODE_BORDER && r_fidx != 2'd3) begin
                    n_fidx  = r_fidx + 2'd1;
                    n_state = ST_SETUP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_FILL: begin
                // One pixel per cycle, row by row
                if (r_ix == r_xl) begin
                    n_ix = r_x0;
                    if (r_iy == r_yl) begin
                        if (r_mode == MODE_BORDER && r_fidx != 2'd3) begin
                            n_fidx  = r_fidx + 2'd1;
                            n_state = ST_SETUP;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end else begin
                        n_iy = r_iy + 1'b1;
                    end
                end else begin
                    n_ix = r_ix + 1'b1;
                end
            end
            ST_READ: begin
                n_inside = rd_inside;
                n_state  = ST_RDCAP;
            end
            ST_RDCAP: begin
                n_word  = r_inside ? r_mem_q : '0;
                n_hit   = r_inside;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (r_init) begin
                    // Power-up clear finished: no result
                    n_init  = 1'b0;
                    n_state = ST_IDLE;
                end else if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_word  = r_word;
                    n_o_hit   = r_hit;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Start the power-up clear sweep with color zero
            r_state   <= ST_SETUP;
            r_mode    <= MODE_CLEAR;
            r_init    <= 1'b1;
            r_fidx    <= '0;
            r_hit     <= 1'b0;
            r_color   <= '0;
            r_word    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_init    <= n_init;
            r_fidx    <= n_fidx;
            r_hit     <= n_hit;
            r_color   <= n_color;
            r_word    <= n_word;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_inside <= n_inside;
        r_x <= n_x; r_y <= n_y; r_w <= n_w; r_h <= n_h; r_t <= n_t;
        r_sx <= n_sx; r_ex <= n_ex; r_sy <= n_sy; r_ey <= n_ey;
        r_x0 <= n_x0; r_xl <= n_xl; r_ix <= n_ix;
        r_yl <= n_yl; r_iy <= n_iy;
        r_o_word <= n_o_word;
        r_o_hit  <= n_o_hit;
    end

endmodule
